@@ design/kgsc_pkg.sv @@
package kgsc_pkg;

    localparam int NUM_COLS = 9;
    localparam int NUM_ROWS = 7;

    typedef logic [3:0] digit_t;
    typedef logic [2:0] rank_t;

    // Command codes carried on the command port.
    localparam logic [1:0] CMD_KEY     = 2'd0;
    localparam logic [1:0] CMD_ENCRYPT = 2'd1;
    localparam logic [1:0] CMD_DECRYPT = 2'd2;
    localparam logic [1:0] CMD_LITERAL = 2'd3;

    localparam digit_t DIGIT_MAX_ROW = 4'd7;
    localparam digit_t DIGIT_MAX_COL = 4'd9;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_EIGHT   = 8'h38;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERIOD  = 8'h2E;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_INSERT
    } cell_op_t;

    // Command broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        cell_op_t op;
        digit_t   digit;
        logic     key_last;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_INS_HI,
        ST_INS_LO,
        ST_LOOK
    } state_t;

    // Place of a character in the unkeyed grid, as 1-based row and column digits.
    typedef struct packed {
        logic   hit;
        digit_t brow;
        digit_t bcol;
    } char_pos_t;

    function automatic char_pos_t char_pos(input logic [7:0] c);
        char_pos_t  res;
        logic [7:0] k;
        logic [11:0] prod;
        logic [2:0] q;
        logic [5:0] rem;
        res.hit = 1'b1;
        k = 8'd0;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            k = c - CH_UPPER_A;
        end
        else if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
        begin
            k = c - CH_LOWER_A + 8'd26;
        end
        else if (c >= CH_ZERO && c <= CH_EIGHT)
        begin
            k = c - CH_ZERO + 8'd52;
        end
        else if (c == CH_SPACE)
        begin
            k = 8'd61;
        end
        else if (c == CH_PERIOD)
        begin
            k = 8'd62;
        end
        else
        begin
            res.hit = 1'b0;
        end
        // k / 9 for k below 63 by the reciprocal 57 / 512.
        prod = 12'(k[5:0]) * 12'd57;
        q = prod[11:9];
        rem = k[5:0] - ({q, 3'b000} + 6'(q));
        res.brow = digit_t'(q) + 4'd1;
        res.bcol = rem[3:0] + 4'd1;
        return res;
    endfunction

    function automatic logic [7:0] base_char(input digit_t rowd, input digit_t cold);
        logic [5:0] r;
        logic [5:0] k;
        logic [7:0] ch;
        r = 6'(rowd) - 6'd1;
        k = {r[2:0], 3'b000} + r + 6'(cold) - 6'd1;
        if (k < 6'd26)
        begin
            ch = CH_UPPER_A + 8'(k);
        end
        else if (k < 6'd52)
        begin
            ch = CH_LOWER_A + 8'(k - 6'd26);
        end
        else if (k < 6'd61)
        begin
            ch = CH_ZERO + 8'(k - 6'd52);
        end
        else if (k == 6'd61)
        begin
            ch = CH_SPACE;
        end
        else
        begin
            ch = CH_PERIOD;
        end
        return ch;
    endfunction

endpackage

@@ design/kgsc_cell.sv @@
module kgsc_cell import kgsc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  logic      ins_ok,
    input  digit_t    init_digit,
    input  rank_t     init_rank,
    input  digit_t    left_digit,
    input  logic      left_filled,
    input  rank_t     left_rank,
    output digit_t    digit,
    output logic      filled,
    output rank_t     rank
);

    digit_t digit_reg, digit_next;
    logic   filled_reg, filled_next;
    rank_t  rank_reg, rank_next;
    logic   low_digit;

    // The rank counts the row digits held in the cells to the left.
    assign low_digit = (ctl.digit <= DIGIT_MAX_ROW);

    always_comb
    begin
        digit_next  = digit_reg;
        filled_next = filled_reg;
        rank_next   = rank_reg;
        case (ctl.op)
            OP_CLEAR:
            begin
                digit_next  = init_digit;
                filled_next = 1'b0;
                rank_next   = init_rank;
            end
            OP_INSERT:
            begin
                if (ins_ok && !filled_reg)
                begin
                    if (left_filled)
                    begin
                        // First free slot takes the new digit.
                        digit_next  = ctl.digit;
                        filled_next = 1'b1;
                    end
                    else if (digit_reg <= ctl.digit)
                    begin
                        // Free digits up to the new one move one place right.
                        digit_next = left_digit;
                        rank_next  = left_rank + rank_t'(low_digit);
                    end
                end
                if (ctl.key_last)
                begin
                    filled_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg  <= init_digit;
            filled_reg <= 1'b1;
            rank_reg   <= init_rank;
        end
        else
        begin
            digit_reg  <= digit_next;
            filled_reg <= filled_next;
            rank_reg   <= rank_next;
        end
    end

    assign digit  = digit_reg;
    assign filled = filled_reg;
    assign rank   = rank_reg;

endmodule

@@ design/kgsc_chain.sv @@
module kgsc_chain import kgsc_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cell_ctl_t                 ctl,
    output digit_t [NUM_COLS-1:0]     digits,
    output rank_t  [NUM_COLS-1:0]     ranks
);

    logic   [NUM_COLS-1:0] filled;
    digit_t [NUM_COLS-1:0] lft_digit;
    logic   [NUM_COLS-1:0] lft_filled;
    rank_t  [NUM_COLS-1:0] lft_rank;
    logic                  found;
    logic                  ins_ok;

    // A digit already among the filled slots is not inserted again.
    always_comb
    begin
        found = 1'b0;
        for (int i = 0; i < NUM_COLS; i++)
        begin
            if (filled[i] && digits[i] == ctl.digit)
            begin
                found = 1'b1;
            end
        end
    end

    assign ins_ok = (ctl.op == OP_INSERT) && (ctl.digit != 4'd0) && !found;

    for (genvar i = 0; i < NUM_COLS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign lft_digit[i]  = '0;
            assign lft_filled[i] = 1'b1;
            assign lft_rank[i]   = '0;
        end
        else
        begin : g_body
            assign lft_digit[i]  = digits[i-1];
            assign lft_filled[i] = filled[i-1];
            assign lft_rank[i]   = ranks[i-1];
        end

        kgsc_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .ins_ok      (ins_ok),
            .init_digit  (digit_t'(i + 1)),
            .init_rank   (rank_t'((i < NUM_ROWS) ? i : NUM_ROWS)),
            .left_digit  (lft_digit[i]),
            .left_filled (lft_filled[i]),
            .left_rank   (lft_rank[i]),
            .digit       (digits[i]),
            .filled      (filled[i]),
            .rank        (ranks[i])
        );
    end

endmodule

@@ design/keyed_grid_substitution_cipher.sv @@
// Channel   Handshake         Payload words
// --------  ----------------  ------------------------------------------------------
// input     start / busy      command, key_first, key_last, data_char,
//                             tens_digit, ones_digit
// result    done (one cycle)  cipher_code, plain_char, bad_code
//
// A word is taken at a rising edge with start high and busy low.
// A key word keeps the block busy through an optional clear, then one insert
// step per key digit through the cell chain; it gives no result.
// Encrypt, decrypt and literal words pass through the lookup state; done is high in the
// cycle after it, and a new word is taken only once the block is idle again.
// Results are flagged by done for one cycle and cannot be stalled by the receiver.
// Reset leaves the identity order 1..9 with all nine slots filled.

module keyed_grid_substitution_cipher import kgsc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        command,
    input  logic              key_first,
    input  logic              key_last,
    input  logic [7:0]        data_char,
    input  logic [3:0]        tens_digit,
    input  logic [3:0]        ones_digit,
    output logic              done,
    output logic signed [8:0] cipher_code,
    output logic [7:0]        plain_char,
    output logic              bad_code
);

    state_t state_reg, state_next;

    // Captured input word.
    logic [1:0] command_reg;
    logic       key_first_reg;
    logic       key_last_reg;
    logic [7:0] data_char_reg;
    digit_t     tens_reg;
    digit_t     ones_reg;

    logic              done_reg, done_next;
    logic signed [8:0] cipher_code_reg, cipher_code_next;
    logic [7:0]        plain_char_reg, plain_char_next;
    logic              bad_code_reg, bad_code_next;

    logic      accept;
    logic      look;
    cell_ctl_t ctl;

    digit_t [NUM_COLS-1:0] digits;
    rank_t  [NUM_COLS-1:0] ranks;

    // Key digit extraction: c/10 by 205/2048, c/100 by 41/4096 (exact for bytes).
    logic [15:0] prod10;
    logic [13:0] prod100;
    logic [4:0]  q10;
    logic [1:0]  q100;
    logic [7:0]  ones_full;
    digit_t      lead_digit;
    digit_t      ones_key;

    // Lookup signals.
    char_pos_t  pos;
    rank_t      enc_rank;
    digit_t     enc_col;
    logic [6:0] enc_code;
    digit_t     dec_row;
    digit_t     dec_col;
    logic       dec_bad;
    logic [7:0] lit_value;

    assign accept = start && !busy;

    assign prod10     = 16'(data_char_reg) * 16'd205;
    assign prod100    = 14'(data_char_reg) * 14'd41;
    assign q10        = prod10[15:11];
    assign q100       = prod100[13:12];
    assign ones_full  = data_char_reg - ({q10, 3'b000} + {2'b00, q10, 1'b0});
    assign ones_key   = ones_full[3:0];

    always_comb
    begin
        if (data_char_reg < 8'd10)
        begin
            lead_digit = 4'd0;
        end
        else if (data_char_reg < 8'd100)
        begin
            lead_digit = q10[3:0];
        end
        else
        begin
            lead_digit = digit_t'(q100);
        end
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (command == CMD_KEY) ? ST_CLEAR : ST_LOOK;
                end
            end
            ST_CLEAR:  state_next = ST_INS_HI;
            ST_INS_HI: state_next = ST_INS_LO;
            ST_INS_LO: state_next = ST_IDLE;
            ST_LOOK:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Output logic of the sequencer: the command broadcast into the chain.
    always_comb
    begin
        busy         = 1'b1;
        look         = 1'b0;
        ctl.op       = OP_HOLD;
        ctl.digit    = 4'd0;
        ctl.key_last = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_CLEAR:
            begin
                ctl.op = key_first_reg ? OP_CLEAR : OP_HOLD;
            end
            ST_INS_HI:
            begin
                ctl.op    = OP_INSERT;
                ctl.digit = lead_digit;
            end
            ST_INS_LO:
            begin
                ctl.op       = OP_INSERT;
                ctl.digit    = ones_key;
                ctl.key_last = key_last_reg;
            end
            ST_LOOK:
            begin
                look = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // The cells always hold the working order: filled slots first, then the
    // missing digits in ascending order, each with its rank among row digits.
    kgsc_chain u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .digits (digits),
        .ranks  (ranks)
    );

    // Encrypt: the base row digit sits in one cell, whose rank is the keyed
    // row; the base column digit's cell position is the keyed column.
    assign pos = char_pos(data_char_reg);

    always_comb
    begin
        enc_rank = '0;
        enc_col  = '0;
        dec_row  = '0;
        dec_col  = '0;
        for (int i = 0; i < NUM_COLS; i++)
        begin
            if (digits[i] == pos.brow)
            begin
                enc_rank = enc_rank | ranks[i];
            end
            if (digits[i] == pos.bcol)
            begin
                enc_col = enc_col | digit_t'(i);
            end
            if (digit_t'(i + 1) == ones_reg)
            begin
                dec_col = dec_col | digits[i];
            end
            if (digits[i] <= DIGIT_MAX_ROW && (4'(ranks[i]) + 4'd1) == tens_reg)
            begin
                dec_row = dec_row | digits[i];
            end
        end
    end

    // row * 10 + col with both counted from one.
    assign enc_code = {1'b0, enc_rank, 3'b000} + {3'b000, enc_rank, 1'b0}
                      + 7'(enc_col) + 7'd11;

    assign dec_bad = (tens_reg == 4'd0) || (tens_reg > DIGIT_MAX_ROW)
                     || (ones_reg == 4'd0) || (ones_reg > DIGIT_MAX_COL);

    assign lit_value = {1'b0, tens_reg, 3'b000} + {3'b000, tens_reg, 1'b0} + 8'(ones_reg);

    always_comb
    begin
        done_next        = look;
        cipher_code_next = cipher_code_reg;
        plain_char_next  = plain_char_reg;
        bad_code_next    = bad_code_reg;
        if (look)
        begin
            cipher_code_next = '0;
            plain_char_next  = '0;
            bad_code_next    = 1'b0;
            case (command_reg)
                CMD_ENCRYPT:
                begin
                    // A byte outside the grid comes back negated; byte zero gives zero.
                    if (pos.hit)
                    begin
                        cipher_code_next = signed'(9'(enc_code));
                    end
                    else
                    begin
                        cipher_code_next = signed'(9'd0 - {1'b0, data_char_reg});
                    end
                end
                CMD_DECRYPT:
                begin
                    bad_code_next = dec_bad;
                    if (!dec_bad)
                    begin
                        plain_char_next = base_char(dec_row, dec_col);
                    end
                end
                CMD_LITERAL:
                begin
                    plain_char_next = lit_value;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            command_reg   <= command;
            key_first_reg <= key_first;
            key_last_reg  <= key_last;
            data_char_reg <= data_char;
            tens_reg      <= tens_digit;
            ones_reg      <= ones_digit;
        end
        cipher_code_reg <= cipher_code_next;
        plain_char_reg  <= plain_char_next;
        bad_code_reg    <= bad_code_next;
    end

    assign done        = done_reg;
    assign cipher_code = cipher_code_reg;
    assign plain_char  = plain_char_reg;
    assign bad_code    = bad_code_reg;

endmodule

@@ tb/grid_cipher_scoreboard_pkg.sv @@
`timescale 1ns / 100ps
package grid_cipher_scoreboard_pkg;
    import kgsc_pkg::*;

    typedef struct packed {
        logic signed [8:0] cipher_code;
        logic [7:0]        plain_char;
        logic              bad_code;
    } cipher_result_t;

    class grid_cipher_scoreboard;
        digit_t         column_order [NUM_COLS];
        digit_t         full_order [NUM_COLS];
        digit_t         row_order [NUM_ROWS];
        logic [7:0]     grid [NUM_ROWS][NUM_COLS];
        int unsigned    slots_filled;
        cipher_result_t awaited_results [$];
        int unsigned    mismatches;

        function new();
            for (int i = 0; i < NUM_COLS; i++)
            begin
                column_order[i] = digit_t'(i + 1);
            end
            slots_filled = NUM_COLS;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction

        function void insert_digit(int unsigned d);
            if (d == 0 || d > 9 || slots_filled >= NUM_COLS)
            begin
                return;
            end
            for (int i = 0; i < slots_filled; i++)
            begin
                if (column_order[i] == d)
                begin
                    return;
                end
            end
            column_order[slots_filled] = digit_t'(d);
            slots_filled++;
        endfunction

        // Filled slots first, then the digits that are still missing, in ascending order.
        function void complete_order();
            int unsigned n;
            logic [15:0] seen;
            n = (slots_filled > NUM_COLS) ? NUM_COLS : slots_filled;
            seen = '0;
            for (int i = 0; i < n; i++)
            begin
                full_order[i] = column_order[i];
                seen[column_order[i]] = 1'b1;
            end
            for (int d = 1; d <= 9; d++)
            begin
                if (n < NUM_COLS && !seen[d])
                begin
                    full_order[n] = digit_t'(d);
                    n++;
                end
            end
        endfunction

        function logic [7:0] base_glyph(int k);
            if (k < 26)
            begin
                return CH_UPPER_A + 8'(k);
            end
            if (k < 52)
            begin
                return CH_LOWER_A + 8'(k - 26);
            end
            if (k < 61)
            begin
                return CH_ZERO + 8'(k - 52);
            end
            if (k == 61)
            begin
                return CH_SPACE;
            end
            return CH_PERIOD;
        endfunction

        function void build_grid();
            int r;
            r = 0;
            complete_order();
            for (int i = 0; i < NUM_COLS; i++)
            begin
                if (full_order[i] >= 1 && full_order[i] <= DIGIT_MAX_ROW && r < NUM_ROWS)
                begin
                    row_order[r] = full_order[i];
                    r = r + 1;
                end
            end
            while (r < NUM_ROWS)
            begin
                row_order[r] = digit_t'(r + 1);
                r = r + 1;
            end
            for (int i = 0; i < NUM_ROWS; i++)
            begin
                for (int j = 0; j < NUM_COLS; j++)
                begin
                    grid[i][j] = base_glyph((int'(row_order[i]) - 1) * NUM_COLS
                                            + int'(full_order[j]) - 1);
                end
            end
        endfunction

        function void note_word(logic [1:0] command, logic key_first, logic key_last,
                                logic [7:0] data_char, logic [3:0] tens, logic [3:0] ones);
            cipher_result_t res;
            int unsigned    c;
            int unsigned    code;
            c = data_char;
            if (command == CMD_KEY)
            begin
                if (key_first)
                begin
                    for (int i = 0; i < NUM_COLS; i++)
                    begin
                        column_order[i] = '0;
                    end
                    slots_filled = 0;
                end
                insert_digit((c < 10) ? 0 : ((c < 100) ? c / 10 : c / 100));
                insert_digit(c % 10);
                if (key_last)
                begin
                    complete_order();
                    column_order = full_order;
                    slots_filled = NUM_COLS;
                end
                return;
            end
            res = '0;
            if (command == CMD_ENCRYPT)
            begin
                code = (512 - c) % 512;
                build_grid();
                for (int i = 0; i < NUM_ROWS; i++)
                begin
                    for (int j = 0; j < NUM_COLS; j++)
                    begin
                        if (grid[i][j] == data_char && code >= 256)
                        begin
                            code = (i + 1) * 10 + (j + 1);
                        end
                    end
                end
                if (c == 0)
                begin
                    code = 0;
                end
                res.cipher_code = 9'(code);
            end
            else if (command == CMD_DECRYPT)
            begin
                if (tens < 1 || tens > DIGIT_MAX_ROW || ones < 1 || ones > DIGIT_MAX_COL)
                begin
                    res.bad_code = 1'b1;
                end
                else
                begin
                    build_grid();
                    res.plain_char = grid[tens - 1][ones - 1];
                end
            end
            else
            begin
                res.plain_char = 8'(int'(tens) * 10 + int'(ones));
            end
            awaited_results = {awaited_results, res};
        endfunction

        function void check_result(cipher_result_t got);
            cipher_result_t want;
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: result with none awaited:", $realtime);
                    $display("    got cipher_code %0d plain_char %02h bad_code %0b",
                             got.cipher_code, got.plain_char, got.bad_code);
                end
                return;
            end
            want = awaited_results.pop_front();
            if (got.cipher_code !== want.cipher_code || got.plain_char !== want.plain_char
                || got.bad_code !== want.bad_code)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: mismatch: expected cipher_code %0d plain_char %02h bad_code %0b",
                             $realtime, want.cipher_code, want.plain_char, want.bad_code);
                    $display("    got cipher_code %0d plain_char %02h bad_code %0b",
                             got.cipher_code, got.plain_char, got.bad_code);
                end
            end
        endfunction
    endclass

endpackage

@@ tb/tb.sv @@
`timescale 1ns / 100ps
module tb;
    import kgsc_pkg::*;
    import grid_cipher_scoreboard_pkg::*;

    // Every input of the block starts at a known value; reset is held low from time zero.
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [1:0]        command = CMD_KEY;
    logic              key_first = 1'b0;
    logic              key_last = 1'b0;
    logic [7:0]        data_char = 8'd0;
    logic [3:0]        tens_digit = 4'd0;
    logic [3:0]        ones_digit = 4'd0;
    logic              busy;
    logic              done;
    logic signed [8:0] cipher_code;
    logic [7:0]        plain_char;
    logic              bad_code;

    grid_cipher_scoreboard sb = new();

    int unsigned words_sent = 0;
    // While this counts down the sender offers words back to back, with no gaps.
    int unsigned quiet_words = 0;

    keyed_grid_substitution_cipher dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .key_first   (key_first),
        .key_last    (key_last),
        .data_char   (data_char),
        .tens_digit  (tens_digit),
        .ones_digit  (ones_digit),
        .done        (done),
        .cipher_code (cipher_code),
        .plain_char  (plain_char),
        .bad_code    (bad_code)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Monitor. Inputs only change at the falling edge, and the block updates its outputs
    // after the rising edge, so values read here are the ones the block itself sees.
    // A word is noted before a result is checked, although a result can never belong
    // to a word accepted at the same edge.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            sb.note_word(command, key_first, key_last, data_char, tens_digit, ones_digit);
        end
        if (rst_n && done)
        begin
            sb.check_result(cipher_result_t'{cipher_code, plain_char, bad_code});
        end
    end

    // Offers one word and holds it until the block takes it, then returns at the
    // following falling edge. Start stays high, so a word that follows at once goes
    // out without start dropping in between.
    task automatic send_word(input logic [1:0] cmd, input logic kf, input logic kl,
                             input logic [7:0] ch, input logic [3:0] tens,
                             input logic [3:0] ones);
        start      <= 1'b1;
        command    <= cmd;
        key_first  <= kf;
        key_last   <= kl;
        data_char  <= ch;
        tens_digit <= tens;
        ones_digit <= ones;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        @(negedge clk);
        words_sent++;
    endtask

    // A random gap after a word: mostly none or short, now and then long. Start only
    // drops when the gap is not empty.
    task automatic idle_gap();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 99);
        if (quiet_words > 0)
        begin
            quiet_words--;
            n = 0;
        end
        else if (pick < 3)
        begin
            quiet_words = $urandom_range(20, 80);
            n = 0;
        end
        else if (pick < 50)
        begin
            n = 0;
        end
        else if (pick < 82)
        begin
            n = $urandom_range(1, 3);
        end
        else if (pick < 97)
        begin
            n = $urandom_range(4, 12);
        end
        else
        begin
            n = $urandom_range(20, 60);
        end
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Holds off the sender until every awaited result has come back. The loop waits
    // before its first test, so start is never lowered and raised at the same edge.
    task automatic drain_results();
        start <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (sb.pending() != 0);
    endtask

    // A byte that is in the grid: a letter of either case, a digit from 0 to 8,
    // a space or a period.
    function automatic logic [7:0] grid_byte();
        case ($urandom_range(0, 4))
            0: return CH_UPPER_A + 8'($urandom_range(0, 25));
            1: return CH_LOWER_A + 8'($urandom_range(0, 25));
            2: return CH_ZERO + 8'($urandom_range(0, 8));
            3: return CH_SPACE;
            default: return CH_PERIOD;
        endcase
    endfunction

    // One encrypt, decrypt or literal word with content mostly inside the grid.
    // The fields that the command does not use carry random values as well.
    task automatic send_text_word();
        int unsigned pick;
        logic [7:0]  ch;
        logic [3:0]  tens;
        logic [3:0]  ones;
        pick = $urandom_range(0, 99);
        ch   = 8'($urandom_range(0, 255));
        tens = 4'($urandom_range(0, 15));
        ones = 4'($urandom_range(0, 15));
        if (pick < 45)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                ch = grid_byte();
            end
            send_word(CMD_ENCRYPT, 1'($urandom), 1'($urandom), ch, tens, ones);
        end
        else if (pick < 85)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                tens = 4'($urandom_range(1, 7));
                ones = 4'($urandom_range(1, 9));
            end
            send_word(CMD_DECRYPT, 1'($urandom), 1'($urandom), ch, tens, ones);
        end
        else
        begin
            send_word(CMD_LITERAL, 1'($urandom), 1'($urandom), ch, tens, ones);
        end
        idle_gap();
    endtask

    initial
    begin
        int unsigned pick;
        int unsigned key_len;
        logic        kf;
        logic        kl;
        logic [7:0]  ch;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, starting from the identity order left by reset.
        // Encrypt the first letter, the last lower-case letter, the last digit, the space
        // and the period, byte zero and the largest byte.
        send_word(CMD_ENCRYPT, 1'b0, 1'b0, CH_UPPER_A, 4'd0, 4'd0);
        send_word(CMD_ENCRYPT, 1'b0, 1'b0, CH_LOWER_Z, 4'd0, 4'd0);
        send_word(CMD_ENCRYPT, 1'b0, 1'b0, CH_EIGHT, 4'd0, 4'd0);
        send_word(CMD_ENCRYPT, 1'b0, 1'b0, CH_SPACE, 4'd0, 4'd0);
        send_word(CMD_ENCRYPT, 1'b1, 1'b1, CH_PERIOD, 4'd15, 4'd15);
        send_word(CMD_ENCRYPT, 1'b0, 1'b0, 8'd0, 4'd0, 4'd0);
        send_word(CMD_ENCRYPT, 1'b0, 1'b0, 8'd255, 4'd0, 4'd0);
        // Decrypt the first and last cells, then digit pairs off the grid,
        // which must raise the flag and leave the character at zero.
        send_word(CMD_DECRYPT, 1'b0, 1'b0, 8'd0, 4'd1, 4'd1);
        send_word(CMD_DECRYPT, 1'b0, 1'b0, 8'd0, 4'd7, 4'd9);
        send_word(CMD_DECRYPT, 1'b0, 1'b0, 8'd0, 4'd0, 4'd5);
        send_word(CMD_DECRYPT, 1'b0, 1'b0, 8'd0, 4'd8, 4'd1);
        send_word(CMD_DECRYPT, 1'b0, 1'b0, 8'd0, 4'd3, 4'd0);
        send_word(CMD_DECRYPT, 1'b0, 1'b0, 8'd0, 4'd15, 4'd15);
        // Literal pairs: the smallest value, and digits above nine giving 165.
        send_word(CMD_LITERAL, 1'b0, 1'b0, 8'd0, 4'd0, 4'd0);
        send_word(CMD_LITERAL, 1'b0, 1'b0, 8'd0, 4'd15, 4'd15);
        // A new key: 75 gives 7 and 5, 3 has no leading digit, and lookups in the
        // middle of the key see the filled slots followed by the missing digits.
        send_word(CMD_KEY, 1'b1, 1'b0, 8'd75, 4'd0, 4'd0);
        send_word(CMD_KEY, 1'b0, 1'b0, 8'd3, 4'd0, 4'd0);
        send_word(CMD_ENCRYPT, 1'b0, 1'b0, 8'h51, 4'd0, 4'd0);
        send_word(CMD_DECRYPT, 1'b0, 1'b0, 8'd0, 4'd2, 4'd3);
        // 200 takes its leading digit from the hundreds; byte zero ends the key.
        send_word(CMD_KEY, 1'b0, 1'b0, 8'd200, 4'd0, 4'd0);
        send_word(CMD_KEY, 1'b0, 1'b1, 8'd0, 4'd0, 4'd0);
        // A key word while the order is full inserts nothing, even with key_last.
        send_word(CMD_KEY, 1'b0, 1'b1, 8'd120, 4'd0, 4'd0);
        send_word(CMD_ENCRYPT, 1'b0, 1'b0, 8'd120, 4'd0, 4'd0);
        send_word(CMD_DECRYPT, 1'b0, 1'b0, 8'd0, 4'd4, 4'd4);
        drain_results();

        // Random part. Most of it is keys followed by runs of text words, since only
        // a fresh key moves the grid away from the order it already holds. Key words
        // cover the whole byte range, so keys of every length and digit pattern come
        // up; now and then a key is left open, or a lookup falls in the middle of it.
        while (words_sent < 1650)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                key_len = $urandom_range(1, 12);
                for (int k = 0; k < key_len; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        send_text_word();
                    end
                    kf = (k == 0) ? ($urandom_range(0, 15) != 0) : 1'b0;
                    kl = (k == key_len - 1) ? ($urandom_range(0, 7) != 0) : 1'b0;
                    ch = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(32, 126))
                                                    : 8'($urandom_range(0, 255));
                    send_word(CMD_KEY, kf, kl, ch, 4'($urandom), 4'($urandom));
                    idle_gap();
                end
            end
            else if (pick < 90)
            begin
                repeat ($urandom_range(4, 20)) send_text_word();
            end
            else
            begin
                // Noise: every field fully random, the command included.
                send_word(2'($urandom), 1'($urandom), 1'($urandom), 8'($urandom),
                          4'($urandom), 4'($urandom));
                idle_gap();
            end
            if ($urandom_range(0, 39) == 0)
            begin
                drain_results();
            end
        end

        // Let every awaited result arrive, then keep the clock running so that
        // a stray result would still be caught.
        drain_results();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Guard against a block that stops taking words or stops answering.
    initial
    begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
